### rtl/clps_pkg.sv
package clps_pkg;

   localparam int CW        = 13;
   localparam int EW        = 14;
   localparam int ADDR_BITS = 25;
   localparam int PIX_BITS  = 12;

   localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
   localparam logic [2:0] REG_CLIP_TOP    = 3'd1;
   localparam logic [2:0] REG_CLIP_RIGHT  = 3'd2;
   localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
   localparam logic [2:0] REG_ROW_PITCH   = 3'd4;

   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // setup result handed from the front part to the walker
   typedef struct packed {
      logic          line;       // 1: new line command, 0: step tick
      logic          rejected;
      logic [CW-1:0] x0;
      logic [CW-1:0] y0;
      logic [CW-1:0] major;
      logic [CW-1:0] minor;
      logic          x_major;
      logic          x_neg;
      logic          y_neg;
   } cmd_type;

   typedef struct packed {
      logic [11:0] left;
      logic [11:0] top;
      logic [11:0] right;
      logic [11:0] bottom;
      logic [13:0] pitch;
   } clip_cfg_type;

endpackage

### rtl/clps_if.sv
interface clps_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface clps_rsp_if;
   logic        valid;
   logic        ready;
   logic        pixel_valid;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   logic [24:0] pixel_address;
   logic        last_pixel;
   logic        line_rejected;
   modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_address,
                   last_pixel, line_rejected, input ready);
   modport sink   (input valid, pixel_valid, pixel_x, pixel_y, pixel_address,
                   last_pixel, line_rejected, output ready);
endinterface

interface clps_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [13:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/clps_div.sv
// Signed truncating divider, restoring, one quotient bit per cycle.
module clps_div
   import clps_pkg::*;
#(
   parameter int W = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] num,
   input  logic signed [W-1:0] den,
   output logic                done,
   output logic signed [W-1:0] quo
);
   localparam int CB = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  q_ff, q_in;
   logic [W-1:0]  d_ff, d_in;
   logic          neg_ff, neg_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W-1:0]  an, ad;

   always_comb begin
      an = num[W-1] ? W'(-num) : W'(num);
      ad = den[W-1] ? W'(-den) : W'(den);
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[W-1]} - {1'b0, d_ff};
      if (start) begin
         rem_in  = '0;
         q_in    = an;
         d_in    = ad;
         neg_in  = num[W-1] ^ den[W-1];
         cnt_in  = CB'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            q_in   = {q_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], q_ff[W-1]};
            q_in   = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? W'(-q_ff) : W'(q_ff);
endmodule

### rtl/clps_front.sv
// Line setup: rejection tests, y clip, x clip, direction and deltas; ticks pass straight through.
module clps_front
   import clps_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  clip_cfg_type                 cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_kind,
   input  logic signed [COORD_BITS-1:0] in_x1,
   input  logic signed [COORD_BITS-1:0] in_y1,
   input  logic signed [COORD_BITS-1:0] in_x2,
   input  logic signed [COORD_BITS-1:0] in_y2,
   output logic                         out_valid,
   input  logic                         out_ready,
   output cmd_type                      out_cmd
);
   // coordinates carry three extra bits and the product is twice that width plus two
   localparam int VW = COORD_BITS + 3;
   localparam int DW = 2 * VW + 2;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_YSORT  = 9'b000000010,
      ST_TOP    = 9'b000000100,
      ST_BOT    = 9'b000001000,
      ST_XSORT  = 9'b000010000,
      ST_LEFT   = 9'b000100000,
      ST_RIGHT  = 9'b001000000,
      ST_FINISH = 9'b010000000,
      ST_WAIT   = 9'b100000000
   } st_type;

   st_type               st_ff, st_in;
   logic signed [VW-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [VW-1:0] x1_in, y1_in, x2_in, y2_in;
   logic                 busy_div_ff, busy_div_in;
   logic signed [DW-1:0] num_ff, num_in, den_ff, den_in;
   logic                 dstart_ff, dstart_in;
   logic                 done;
   logic signed [DW-1:0] quo;
   cmd_type              cmd_ff, cmd_in;
   logic                 ov_ff, ov_in;

   logic signed [VW-1:0] l, t, r, b, dx, dy, adx, ady;
   logic                 empty, out_x, out_y;

   // delta times edge distance, VW by VW signed
   function automatic logic signed [DW-1:0] mul_vw(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] c);
      logic signed [2*VW-1:0] p;
      p = a * c;
      return DW'(p);
   endfunction

   clps_div #(.W(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (dstart_ff),
      .num   (num_ff),
      .den   (den_ff),
      .done  (done),
      .quo   (quo)
   );

   always_comb begin
      l = VW'($signed({1'b0, cfg.left}));
      t = VW'($signed({1'b0, cfg.top}));
      r = VW'($signed({1'b0, cfg.right}));
      b = VW'($signed({1'b0, cfg.bottom}));
      empty = (r <= l) || (b <= t);
      out_x = (x1_ff < l && x2_ff < l) || (x1_ff >= r && x2_ff >= r);
      out_y = (y1_ff < t && y2_ff < t) || (y1_ff >= b && y2_ff >= b);
      dx  = x2_ff - x1_ff;
      dy  = y2_ff - y1_ff;
      adx = dx[VW-1] ? -dx : dx;
      ady = dy[VW-1] ? -dy : dy;

      st_in       = st_ff;
      x1_in = x1_ff; y1_in = y1_ff; x2_in = x2_ff; y2_in = y2_ff;
      busy_div_in = 1'b0;
      dstart_in   = 1'b0;
      num_in      = num_ff;
      den_in      = den_ff;
      cmd_in      = cmd_ff;
      ov_in       = ov_ff;
      in_ready    = 1'b0;
      if (ov_ff && out_ready) ov_in = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            in_ready = !ov_ff || out_ready;
            if (in_valid && in_ready) begin
               x1_in = VW'(in_x1); y1_in = VW'(in_y1);
               x2_in = VW'(in_x2); y2_in = VW'(in_y2);
               cmd_in = '0;
               if (in_kind == KIND_TICK) begin
                  ov_in = 1'b1;
               end else begin
                  cmd_in.line = 1'b1;
                  st_in = ST_YSORT;
               end
            end
         end
         ST_YSORT: begin
            if (empty || out_x || out_y) begin
               cmd_in.rejected = 1'b1;
               st_in = ST_WAIT;
            end else begin
               if (y1_ff > y2_ff) begin
                  x1_in = x2_ff; y1_in = y2_ff; x2_in = x1_ff; y2_in = y1_ff;
               end
               st_in = ST_TOP;
            end
         end
         ST_TOP: begin
            if (busy_div_ff) begin
               busy_div_in = !done;
               if (done) begin
                  x1_in = x1_ff + VW'(quo);
                  y1_in = t;
                  st_in = ST_BOT;
               end
            end else if (y1_ff < t && y2_ff != y1_ff) begin
               num_in = mul_vw(dx, t - y1_ff);
               den_in = DW'(dy);
               dstart_in = 1'b1;
               busy_div_in = 1'b1;
            end else begin
               st_in = ST_BOT;
            end
         end
         ST_BOT: begin
            if (busy_div_ff) begin
               busy_div_in = !done;
               if (done) begin
                  x2_in = x2_ff + VW'(quo);
                  y2_in = b;
                  st_in = ST_XSORT;
               end
            end else if (y2_ff > b && y2_ff != y1_ff) begin
               num_in = mul_vw(dx, b - y2_ff);
               den_in = DW'(dy);
               dstart_in = 1'b1;
               busy_div_in = 1'b1;
            end else begin
               st_in = ST_XSORT;
            end
         end
         ST_XSORT: begin
            if (out_x) begin
               cmd_in.rejected = 1'b1;
               st_in = ST_WAIT;
            end else begin
               if (x1_ff > x2_ff) begin
                  x1_in = x2_ff; y1_in = y2_ff; x2_in = x1_ff; y2_in = y1_ff;
               end
               st_in = ST_LEFT;
            end
         end
         ST_LEFT: begin
            if (busy_div_ff) begin
               busy_div_in = !done;
               if (done) begin
                  y1_in = y1_ff + VW'(quo);
                  x1_in = l;
                  st_in = ST_RIGHT;
               end
            end else if (x1_ff < l && x2_ff != x1_ff) begin
               num_in = mul_vw(dy, l - x1_ff);
               den_in = DW'(dx);
               dstart_in = 1'b1;
               busy_div_in = 1'b1;
            end else begin
               st_in = ST_RIGHT;
            end
         end
         ST_RIGHT: begin
            if (busy_div_ff) begin
               busy_div_in = !done;
               if (done) begin
                  y2_in = y2_ff + VW'(quo);
                  x2_in = r;
                  st_in = ST_FINISH;
               end
            end else if (x2_ff > r && x2_ff != x1_ff) begin
               num_in = mul_vw(dy, r - x2_ff);
               den_in = DW'(dx);
               dstart_in = 1'b1;
               busy_div_in = 1'b1;
            end else begin
               st_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_y || (dx == '0 && dy == '0)) begin
               cmd_in.rejected = 1'b1;
            end else begin
               cmd_in.x_neg   = dx[VW-1];
               cmd_in.y_neg   = dy[VW-1];
               cmd_in.x_major = adx > ady;
               cmd_in.major   = CW'(adx > ady ? adx : ady);
               cmd_in.minor   = CW'(adx > ady ? ady : adx);
               cmd_in.x0      = CW'(x1_ff);
               cmd_in.y0      = CW'(y1_ff);
            end
            st_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!ov_ff || out_ready) begin
               ov_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         ov_ff       <= 1'b0;
         busy_div_ff <= 1'b0;
         dstart_ff   <= 1'b0;
      end else begin
         st_ff       <= st_in;
         ov_ff       <= ov_in;
         busy_div_ff <= busy_div_in;
         dstart_ff   <= dstart_in;
      end
      x1_ff  <= x1_in; y1_ff <= y1_in; x2_ff <= x2_in; y2_ff <= y2_in;
      num_ff <= num_in;
      den_ff <= den_in;
      cmd_ff <= cmd_in;
   end

   assign out_valid = ov_ff;
   assign out_cmd   = cmd_ff;

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> st_ff == ST_IDLE) else $error("front ready outside idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> $stable(out_cmd)) else $error("command changed");
   a_div_one: assert property (@(posedge clock) disable iff (reset)
      dstart_ff |-> busy_div_ff) else $error("divider start lost");
endmodule

### rtl/clps_queue.sv
// Two-entry command queue between setup and walker.
module clps_queue
   import clps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);
   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_cmd   = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_cmd;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff) else $error("pointer slip");
   a_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("push lost");
endmodule

### rtl/clps_walk.sv
// Bresenham walker with registered result stage.
module clps_walk
   import clps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  clip_cfg_type cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  cmd_type      in_cmd,
   clps_rsp_if.source   rsp
);
   logic          act_ff, act_in;
   logic [CW-1:0] cx_ff, cx_in, cy_ff, cy_in, maj_ff, maj_in, min_ff, min_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [EW-1:0] err_ff, err_in, esum;
   logic          xm_ff, xm_in, xn_ff, xn_in, yn_ff, yn_in;
   logic          ov_ff, ov_in;
   logic          pv_ff, pv_in, last_ff, last_in, rej_ff, rej_in;
   logic [11:0]   px_ff, px_in, py_ff, py_in;
   logic [11:0]   ax_ff, ax_in;
   logic [25:0]   prod;
   logic [24:0]   addr;
   logic [CW-1:0] sx, sy;
   logic          take;

   assign in_ready = !ov_ff || rsp.ready;
   assign take     = in_valid && in_ready;
   // multiply sits after the output register
   assign prod = py_ff * cfg.pitch;
   assign addr = prod[24:0] + 25'(ax_ff);

   always_comb begin
      act_in = act_ff; cx_in = cx_ff; cy_in = cy_ff; maj_in = maj_ff;
      min_in = min_ff; steps_in = steps_ff; err_in = err_ff;
      xm_in = xm_ff; xn_in = xn_ff; yn_in = yn_ff;
      ov_in = ov_ff && !rsp.ready;
      pv_in = pv_ff; last_in = last_ff; rej_in = rej_ff;
      px_in = px_ff; py_in = py_ff; ax_in = ax_ff;
      sx = xn_ff ? '1 : CW'(1);
      sy = yn_ff ? '1 : CW'(1);
      esum = err_ff + EW'(min_ff);
      if (take) begin
         ov_in = 1'b1;
         pv_in = 1'b0; last_in = 1'b0; rej_in = 1'b0;
         px_in = '0; py_in = '0; ax_in = '0;
         if (in_cmd.line) begin
            rej_in = in_cmd.rejected;
            act_in = !in_cmd.rejected;
            cx_in = in_cmd.x0; cy_in = in_cmd.y0;
            maj_in = in_cmd.major; min_in = in_cmd.minor;
            steps_in = in_cmd.major; err_in = '0;
            xm_in = in_cmd.x_major; xn_in = in_cmd.x_neg; yn_in = in_cmd.y_neg;
         end else if (act_ff) begin
            pv_in = 1'b1;
            px_in = cx_ff[11:0]; py_in = cy_ff[11:0]; ax_in = cx_ff[11:0];
            last_in = steps_ff <= CW'(1);
            if (xm_ff) cx_in = cx_ff + sx;
            else       cy_in = cy_ff + sy;
            err_in = esum;
            if (esum >= EW'(maj_ff)) begin
               err_in = esum - EW'(maj_ff);
               if (xm_ff) cy_in = cy_ff + sy;
               else       cx_in = cx_ff + sx;
            end
            if (steps_ff <= CW'(1)) begin
               steps_in = '0;
               act_in = 1'b0;
            end else begin
               steps_in = steps_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0; ov_ff <= 1'b0; steps_ff <= '0;
         cx_ff <= '0; cy_ff <= '0; maj_ff <= '0; min_ff <= '0; err_ff <= '0;
         xm_ff <= 1'b0; xn_ff <= 1'b0; yn_ff <= 1'b0;
      end else begin
         act_ff <= act_in; ov_ff <= ov_in; steps_ff <= steps_in;
         cx_ff <= cx_in; cy_ff <= cy_in; maj_ff <= maj_in; min_ff <= min_in;
         err_ff <= err_in; xm_ff <= xm_in; xn_ff <= xn_in; yn_ff <= yn_in;
      end
      pv_ff <= pv_in; last_ff <= last_in; rej_ff <= rej_in;
      px_ff <= px_in; py_ff <= py_in; ax_ff <= ax_in;
   end

   assign rsp.valid         = ov_ff;
   assign rsp.pixel_valid   = pv_ff;
   assign rsp.pixel_x       = px_ff;
   assign rsp.pixel_y       = py_ff;
   assign rsp.pixel_address = addr;
   assign rsp.last_pixel    = last_ff;
   assign rsp.line_rejected = rej_ff;

   a_excl: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> !(pv_ff && rej_ff)) else $error("pixel on rejected line");
   a_last: assert property (@(posedge clock) disable iff (reset)
      take && !in_cmd.line && act_ff && steps_ff <= CW'(1) |=> !act_ff)
      else $error("walk did not end");
   a_active: assert property (@(posedge clock) disable iff (reset)
      act_ff |-> steps_ff != '0) else $error("active with no steps");
endmodule

### rtl/clipped_line_pixel_stepper.sv
// Channel | Dir | Handshake   | Payload
// req     | in  | valid/ready | kind, start_x, start_y, end_x, end_y
// rsp     | out | valid/ready | pixel_valid, pixel_x/y, pixel_address, last, rejected
// csr     | in  | valid/ready | index (3b), data (14b), always ready
//
// Ticks: one per cycle through setup, queue and walker when nothing stalls.
// Line request: setup time is set by the shared serial divider (one quotient
// bit per cycle, up to four clip divisions).
// Reset clears control state; clip registers come up empty, pitch 1.
// A stalled rsp fills the walker output, then the queue, then the setup stage.
module clipped_line_pixel_stepper
   import clps_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   clps_req_if.sink              req,
   clps_rsp_if.source            rsp,
   clps_csr_if.sink              csr
);
   clip_cfg_type cfg_ff, cfg_in;
   logic         f_valid, f_ready, q_valid, q_ready;
   cmd_type      f_cmd, q_cmd;

   // register file; writes must come only while idle, which the block does not enforce
   assign csr.ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_CLIP_LEFT:   cfg_in.left   = csr.data[11:0];
            REG_CLIP_TOP:    cfg_in.top    = csr.data[11:0];
            REG_CLIP_RIGHT:  cfg_in.right  = csr.data[11:0];
            REG_CLIP_BOTTOM: cfg_in.bottom = csr.data[11:0];
            REG_ROW_PITCH:   cfg_in.pitch  = csr.data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{left: '0, top: '0, right: '0, bottom: '0, pitch: 14'd1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: clipping and setup
   clps_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_kind   (req.kind),
      .in_x1     (req.start_x),
      .in_y1     (req.start_y),
      .in_x2     (req.end_x),
      .in_y2     (req.end_y),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_cmd   (f_cmd)
   );

   // decoupling queue
   clps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   // back: pixel walk
   clps_walk u_walk (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (q_valid),
      .in_ready (q_ready),
      .in_cmd   (q_cmd),
      .rsp      (rsp)
   );

   a_pitch: assert property (@(posedge clock)
      $past(reset) |-> cfg_ff.pitch == 14'd1) else $error("pitch reset");
   a_cfg_hold: assert property (@(posedge clock) disable iff (reset)
      !csr.valid |=> $stable(cfg_ff)) else $error("config changed unwritten");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.line_rejected |-> !rsp.last_pixel) else $error("bad result");
endmodule

### dv/clps_tb_if.sv
// Testbench-side helper types; the channel interfaces come from the RTL.
package clps_tb_types;

   typedef struct packed {
      logic        pixel_valid;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [24:0] pixel_address;
      logic        last_pixel;
      logic        line_rejected;
   } pixel_result_type;

endpackage

### dv/clipped_line_pixel_stepper_tb.sv
module clipped_line_pixel_stepper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import clps_pkg::*;
   import clps_tb_types::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clps_req_if #(.COORD_BITS(16)) req_if ();
   clps_rsp_if                    rsp_if ();
   clps_csr_if                    csr_if ();

   clipped_line_pixel_stepper #(.COORD_BITS(16)) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source),
      .csr   (csr_if.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: its own copy of the clip window and walker
   // ---------------------------------------------------------------------
   logic [11:0]   win_left, win_top, win_right, win_bottom;
   logic [13:0]   win_pitch;
   logic          walk_on;
   logic [CW-1:0] walk_x, walk_y, walk_major, walk_minor, walk_left;
   logic [EW-1:0] walk_err;
   logic          walk_xmaj, walk_xneg, walk_yneg;

   pixel_result_type pending_pixels[$];
   int               fail_count = 0;
   int               cycle_count = 0;
   bit               calm_phase = 1'b0;   // no idling in the last part

   localparam int CYCLE_LIMIT = 2_000_000;

   task automatic predictor_reset();
      win_left = '0; win_top = '0; win_right = '0; win_bottom = '0;
      win_pitch = 14'd1;
      walk_on = 1'b0;
      walk_x = '0; walk_y = '0; walk_major = '0; walk_minor = '0; walk_left = '0;
      walk_err = '0;
      walk_xmaj = 1'b0; walk_xneg = 1'b0; walk_yneg = 1'b0;
   endtask

   function automatic bit outside_same_edge(longint ax, longint ay, longint bx,
                                            longint by, bit do_x, bit do_y);
      longint l, t, r, b;
      l = win_left; t = win_top; r = win_right; b = win_bottom;
      return (do_x && ((ax < l && bx < l) || (ax >= r && bx >= r))) ||
             (do_y && ((ay < t && by < t) || (ay >= b && by >= b)));
   endfunction

   // clip both endpoints to the window; 1 when something survives
   function automatic bit clip_to_window(inout longint x1, inout longint y1,
                                         inout longint x2, inout longint y2);
      longint l, t, r, b, tmp;
      l = win_left; t = win_top; r = win_right; b = win_bottom;
      if (r <= l || b <= t) return 1'b0;
      if (outside_same_edge(x1, y1, x2, y2, 1'b1, 1'b1)) return 1'b0;
      if (y1 > y2) begin
         tmp = x1; x1 = x2; x2 = tmp;
         tmp = y1; y1 = y2; y2 = tmp;
      end
      if (y1 < t && y2 != y1) begin
         x1 = x1 + ((x2 - x1) * (t - y1)) / (y2 - y1);
         y1 = t;
      end
      if (y2 > b && y2 != y1) begin
         x2 = x2 + ((x2 - x1) * (b - y2)) / (y2 - y1);
         y2 = b;
      end
      if (outside_same_edge(x1, y1, x2, y2, 1'b1, 1'b0)) return 1'b0;
      if (x1 > x2) begin
         tmp = x1; x1 = x2; x2 = tmp;
         tmp = y1; y1 = y2; y2 = tmp;
      end
      if (x1 < l && x2 != x1) begin
         y1 = y1 + ((y2 - y1) * (l - x1)) / (x2 - x1);
         x1 = l;
      end
      if (x2 > r && x2 != x1) begin
         y2 = y2 + ((y2 - y1) * (r - x2)) / (x2 - x1);
         x2 = r;
      end
      return !outside_same_edge(x1, y1, x2, y2, 1'b0, 1'b1);
   endfunction

   // one request in, one pixel result out
   function automatic pixel_result_type next_pixel(logic kind, logic signed [15:0] sx,
                                                   logic signed [15:0] sy,
                                                   logic signed [15:0] ex,
                                                   logic signed [15:0] ey);
      pixel_result_type res;
      longint x1, y1, x2, y2, dx, dy;
      logic [CW-1:0] stx, sty;
      res = '{default: '0};
      if (kind == KIND_LINE) begin
         x1 = sx; y1 = sy; x2 = ex; y2 = ey;
         walk_on = 1'b0;
         if (!clip_to_window(x1, y1, x2, y2)) begin
            res.line_rejected = 1'b1;
            return res;
         end
         dx = (x2 > x1) ? x2 - x1 : x1 - x2;
         dy = (y2 > y1) ? y2 - y1 : y1 - y2;
         if (dx == 0 && dy == 0) begin
            res.line_rejected = 1'b1;
            return res;
         end
         walk_xneg  = x2 < x1;
         walk_yneg  = y2 < y1;
         walk_xmaj  = dx > dy;
         walk_major = walk_xmaj ? CW'(dx) : CW'(dy);
         walk_minor = walk_xmaj ? CW'(dy) : CW'(dx);
         walk_left  = walk_major;
         walk_err   = '0;
         walk_x     = CW'(x1);
         walk_y     = CW'(y1);
         walk_on    = 1'b1;
         return res;
      end
      if (!walk_on) return res;
      res.pixel_valid   = 1'b1;
      res.pixel_x       = walk_x[11:0];
      res.pixel_y       = walk_y[11:0];
      res.pixel_address = 25'(longint'(walk_y[11:0]) * longint'(win_pitch) +
                              longint'(walk_x[11:0]));
      res.last_pixel    = walk_left <= 1;
      stx = walk_xneg ? '1 : CW'(1);
      sty = walk_yneg ? '1 : CW'(1);
      if (walk_xmaj) walk_x = walk_x + stx;
      else walk_y = walk_y + sty;
      walk_err = walk_err + EW'(walk_minor);
      if (walk_err >= EW'(walk_major)) begin
         walk_err = walk_err - EW'(walk_major);
         if (walk_xmaj) walk_y = walk_y + sty;
         else walk_x = walk_x + stx;
      end
      if (walk_left <= 1) begin
         walk_left = '0;
         walk_on = 1'b0;
      end else begin
         walk_left = walk_left - 1'b1;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   task automatic idle_gap();
      int n;
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 15);
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // valid stays up after the handshake; the next request or an idle drops it
   task automatic send_request(logic kind, logic [15:0] sx, logic [15:0] sy,
                               logic [15:0] ex, logic [15:0] ey, bit has_exp,
                               pixel_result_type exp_res);
      pixel_result_type pred;
      idle_gap();
      req_if.valid   <= 1'b1;
      req_if.kind    <= kind;
      req_if.start_x <= sx;
      req_if.start_y <= sy;
      req_if.end_x   <= ex;
      req_if.end_y   <= ey;
      do @(posedge clock); while (!req_if.ready);
      pred = next_pixel(kind, sx, sy, ex, ey);
      pending_pixels.push_back(has_exp ? exp_res : pred);
   endtask

   task automatic line_request(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
                               logic [15:0] ey);
      send_request(KIND_LINE, sx, sy, ex, ey, 1'b0, '{default: '0});
   endtask

   task automatic tick_request();
      send_request(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 1'b0, '{default: '0});
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);   // a rejected line may still be in setup
   endtask

   task automatic csr_write(logic [2:0] idx, logic [13:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         REG_CLIP_LEFT:   win_left   = value[11:0];
         REG_CLIP_TOP:    win_top    = value[11:0];
         REG_CLIP_RIGHT:  win_right  = value[11:0];
         REG_CLIP_BOTTOM: win_bottom = value[11:0];
         REG_ROW_PITCH:   win_pitch  = value;
         default: ;
      endcase
   endtask

   task automatic set_window(int l, int t, int r, int b, int p);
      drain_results();
      csr_write(REG_CLIP_LEFT, 14'(l));
      csr_write(REG_CLIP_TOP, 14'(t));
      csr_write(REG_CLIP_RIGHT, 14'(r));
      csr_write(REG_CLIP_BOTTOM, 14'(b));
      csr_write(REG_ROW_PITCH, 14'(p));
      csr_if.valid <= 1'b0;
   endtask

   // coordinate near the window, sometimes far outside
   function automatic logic [15:0] pick_coord(int lo, int hi);
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         default: return 16'($urandom_range(lo + 64, hi + 64 + 64) - 64 - 64 + 0);
      endcase
   endfunction

   task automatic random_phase(int l, int t, int r, int b, int p, int lines);
      int n;
      set_window(l, t, r, b, p);
      repeat (lines) begin
         line_request(pick_coord(l, r), pick_coord(t, b), pick_coord(l, r),
                      pick_coord(t, b));
         n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(1, 6);
         repeat (n) tick_request();
      end
   endtask

   // ---------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------
   typedef struct {
      logic             kind;
      logic [15:0]      sx, sy, ex, ey;
      bit               has_exp;
      pixel_result_type exp_res;
   } stim_row_type;

   localparam pixel_result_type NO_PIXEL = '{default: '0};
   localparam pixel_result_type REJECTED = '{1'b0, 12'd0, 12'd0, 25'd0, 1'b0, 1'b1};

   stim_row_type directed_rows[$];

   task automatic add_row(logic kind, int sx, int sy, int ex, int ey, bit has_exp,
                          pixel_result_type exp_res);
      stim_row_type row;
      row = '{kind, 16'(sx), 16'(sy), 16'(ex), 16'(ey), has_exp, exp_res};
      directed_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------------
   // Result sink with random back-pressure and the checker
   // ---------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      pixel_result_type got, want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.pixel_valid, rsp_if.pixel_x, rsp_if.pixel_y,
                    rsp_if.pixel_address, rsp_if.last_pixel, rsp_if.line_rejected};
            if (pending_pixels.size() == 0) begin
               $error("unexpected result");
               fail_count++;
            end else begin
               want = pending_pixels.pop_front();
               if (got.pixel_valid !== want.pixel_valid) begin
                  $error("pixel_valid exp %0h got %0h", want.pixel_valid, got.pixel_valid);
                  fail_count++;
               end
               if (got.pixel_x !== want.pixel_x) begin
                  $error("pixel_x exp %0d got %0d", want.pixel_x, got.pixel_x);
                  fail_count++;
               end
               if (got.pixel_y !== want.pixel_y) begin
                  $error("pixel_y exp %0d got %0d", want.pixel_y, got.pixel_y);
                  fail_count++;
               end
               if (got.pixel_address !== want.pixel_address) begin
                  $error("pixel_address exp %0h got %0h", want.pixel_address,
                         got.pixel_address);
                  fail_count++;
               end
               if (got.last_pixel !== want.last_pixel) begin
                  $error("last_pixel exp %0h got %0h", want.last_pixel, got.last_pixel);
                  fail_count++;
               end
               if (got.line_rejected !== want.line_rejected) begin
                  $error("line_rejected exp %0h got %0h", want.line_rejected,
                         got.line_rejected);
                  fail_count++;
               end
            end
         end
         // random stall bursts, none in the calm phase
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("clipped_line_pixel_stepper_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      req_if.valid = 1'b0;
      req_if.kind = KIND_TICK;
      req_if.start_x = '0; req_if.start_y = '0;
      req_if.end_x = '0;   req_if.end_y = '0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_CLIP_LEFT;
      csr_if.data = '0;
      predictor_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset the window is empty: lines rejected, ticks idle
      add_row(KIND_TICK, 0, 0, 0, 0, 1'b1, NO_PIXEL);
      add_row(KIND_LINE, 0, 0, 10, 10, 1'b1, REJECTED);
      add_row(KIND_TICK, -1, -1, -1, -1, 1'b1, NO_PIXEL);
      foreach (directed_rows[i])
         send_request(directed_rows[i].kind, directed_rows[i].sx, directed_rows[i].sy,
                      directed_rows[i].ex, directed_rows[i].ey,
                      directed_rows[i].has_exp, directed_rows[i].exp_res);
      directed_rows.delete();

      set_window(10, 20, 100, 80, 640);
      add_row(KIND_LINE, -32768, -32768, -32768, 32767, 1'b1, REJECTED); // left of window
      add_row(KIND_LINE, 32767, 0, 32767, 50, 1'b1, REJECTED);           // right of window
      add_row(KIND_LINE, 0, 0, 200, 5, 1'b1, REJECTED);                  // above window
      add_row(KIND_LINE, 0, 90, 200, 32767, 1'b1, REJECTED);             // below window
      add_row(KIND_LINE, 50, 50, 50, 50, 1'b1, REJECTED);                // zero length
      add_row(KIND_LINE, 20, 30, 30, 33, 1'b0, NO_PIXEL);                // x-major
      add_row(KIND_TICK, 0, 0, 0, 0, 1'b0, NO_PIXEL);
      add_row(KIND_TICK, 0, 0, 0, 0, 1'b0, NO_PIXEL);
      add_row(KIND_LINE, 60, 70, 55, 40, 1'b0, NO_PIXEL);                // drop walk, y-major
      add_row(KIND_TICK, 0, 0, 0, 0, 1'b0, NO_PIXEL);
      add_row(KIND_LINE, -32768, -32768, 32767, 32767, 1'b0, NO_PIXEL);  // clipped both ends
      add_row(KIND_TICK, 0, 0, 0, 0, 1'b0, NO_PIXEL);
      add_row(KIND_LINE, 50, 0, 50, 32767, 1'b0, NO_PIXEL);              // reaches bottom edge
      foreach (directed_rows[i])
         send_request(directed_rows[i].kind, directed_rows[i].sx, directed_rows[i].sy,
                      directed_rows[i].ex, directed_rows[i].ey,
                      directed_rows[i].has_exp, directed_rows[i].exp_res);
      repeat (70) tick_request();   // walk to the bottom-edge pixel and past the end

      // inverted window: everything rejected
      set_window(100, 100, 100, 50, 1);
      line_request(16'd100, 16'd60, 16'd110, 16'd90);
      tick_request();

      // extremes of the registers, pitch 0 and full-range pitch wrap
      random_phase(0, 0, 4095, 4095, 14'h3fff, 25);
      random_phase(4090, 4090, 4095, 4095, 0, 10);
      random_phase(0, 0, 1, 4095, 8192, 8);
      random_phase(200, 300, 260, 340, 1920, 12);
      random_phase(0, 0, 64, 64, 64, 12);
      calm_phase = 1'b1;
      random_phase(1000, 2000, 1100, 2050, 4096, 8);

      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("clipped_line_pixel_stepper_tb: clean");
      else
         $display("clipped_line_pixel_stepper_tb: errors");
      $finish;
   end

endmodule
